// ===== hdl/plc_pkg.sv =====
// Shared constants, types and register codes for the particle link contact block.
package plc_pkg;

  localparam int FIELD_W   = 32;
  localparam int POS_W     = 32;
  localparam int DIST_W    = POS_W;
  localparam int SQ_W      = 2 * POS_W;
  localparam int NORM_FRAC = 14;
  localparam int Q_W       = NORM_FRAC + 1;
  localparam int NUM_W     = POS_W + Q_W;
  localparam int NORM_W    = 16;
  localparam int PEN_W     = 32;
  localparam int LEN_W     = 31;
  localparam int REST_W    = 17;
  localparam int CFG_W     = 31;
  localparam int IDX_W     = 2;
  localparam int CMP_W     = 33;

  localparam logic [IDX_W-1:0] REG_KIND   = 2'd0;
  localparam logic [IDX_W-1:0] REG_LENGTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_REST   = 2'd2;

  localparam logic LINK_CABLE = 1'b0;
  localparam logic LINK_ROD   = 1'b1;

  localparam logic [LEN_W-1:0]  LENGTH_RESET = 31'd65536;
  localparam logic [REST_W-1:0] REST_RESET   = 17'd32768;
  localparam logic [REST_W-1:0] REST_ONE     = 17'd65536;

  typedef struct packed {
    logic             sx;
    logic             sy;
    logic [POS_W-1:0] mx;
    logic [POS_W-1:0] my;
  } geom_t;

  typedef struct packed {
    logic              contact;
    logic              flip;
    logic              zero;
    logic              sx;
    logic              sy;
    logic [PEN_W-1:0]  pen;
    logic [REST_W-1:0] bounce;
  } side_t;

endpackage

// ===== hdl/plc_if.sv =====
// Valid/ready channel interfaces for position pairs and contact results.
interface plc_pos_if;
  import plc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] pos_a_x;
  logic signed [FIELD_W-1:0] pos_a_y;
  logic signed [FIELD_W-1:0] pos_b_x;
  logic signed [FIELD_W-1:0] pos_b_y;
  modport source(output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, input ready);
  modport sink(input valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, output ready);
endinterface

interface plc_res_if;
  import plc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     contact_made;
  logic signed [NORM_W-1:0] normal_x;
  logic signed [NORM_W-1:0] normal_y;
  logic [PEN_W-1:0]         penetration;
  logic [REST_W-1:0]        bounce;
  modport source(output valid, contact_made, normal_x, normal_y, penetration, bounce,
                 input ready);
  modport sink(input valid, contact_made, normal_x, normal_y, penetration, bounce,
               output ready);
endinterface

// ===== hdl/particle_link_contact.sv =====
// Cable/rod contact generation for a 2D particle pair.
// Throughput: one word per cycle; the path runs through stage A, B and C registers,
// the 32-stage root, the stage D register, the 15-stage divider and the output register.
// The whole pipeline holds when the result is not taken; nothing is lost or repeated.
// Reset (rst, synchronous): valid bits cleared, cable mode, length 1.0, restitution 0.5.
module particle_link_contact import plc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  plc_pos_if.sink          pos,
  plc_res_if.source        res
);

  function automatic logic [POS_W:0] sat_mag(input logic [POS_W:0] w);
    logic [POS_W-1:0] m;
    if (w[POS_W] != w[POS_W-1]) begin
      m = w[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      m = w[POS_W] ? -w[POS_W-1:0] : w[POS_W-1:0];
    end
    return {w[POS_W], m};
  endfunction

  logic              link_kind;
  logic [LEN_W-1:0]  link_length;
  logic [REST_W-1:0] restitution;
  logic              en;

  logic [POS_W:0]    wx;
  logic [POS_W:0]    wy;
  logic [POS_W:0]    smx;
  logic [POS_W:0]    smy;

  logic              a_v;
  geom_t             a_g;
  logic              b_v;
  logic [SQ_W-1:0]   b_sqx;
  logic [SQ_W-1:0]   b_sqy;
  geom_t             b_g;
  logic              c_v;
  logic [SQ_W-1:0]   c_sum;
  geom_t             c_g;

  logic              s_v;
  logic [DIST_W-1:0] s_root;
  geom_t             s_g;

  logic [CMP_W-1:0]  dist_e;
  logic [CMP_W-1:0]  len_e;
  logic [CMP_W-1:0]  over;
  logic [CMP_W-1:0]  under;
  side_t             side_next;

  logic              d_v;
  side_t             d_side;
  logic [NUM_W-1:0]  d_nx;
  logic [NUM_W-1:0]  d_ny;
  logic [DIST_W-1:0] d_den;

  logic              q_v;
  logic [Q_W-1:0]    q_x;
  logic [Q_W-1:0]    q_y;
  side_t             q_side;
  logic [NORM_W-1:0] mag_x;
  logic [NORM_W-1:0] mag_y;
  logic              show;

  assign en        = !res.valid || res.ready;
  assign pos.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_kind   <= LINK_CABLE;
      link_length <= LENGTH_RESET;
      restitution <= REST_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KIND:   link_kind   <= cfg_data[0];
        REG_LENGTH: link_length <= cfg_data[LEN_W-1:0];
        REG_REST:   restitution <= cfg_data[REST_W-1:0];
        default: ;
      endcase
    end
  end

  // stage A: saturated difference and magnitude
  assign wx  = {pos.pos_b_x[POS_W-1], pos.pos_b_x[POS_W-1:0]}
             - {pos.pos_a_x[POS_W-1], pos.pos_a_x[POS_W-1:0]};
  assign wy  = {pos.pos_b_y[POS_W-1], pos.pos_b_y[POS_W-1:0]}
             - {pos.pos_a_y[POS_W-1], pos.pos_a_y[POS_W-1:0]};
  assign smx = sat_mag(wx);
  assign smy = sat_mag(wy);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else if (en) begin
      a_v <= pos.valid;
      b_v <= a_v;
      c_v <= b_v;
    end
    if (en) begin
      a_g   <= '{sx: smx[POS_W], sy: smy[POS_W], mx: smx[POS_W-1:0], my: smy[POS_W-1:0]};
      b_sqx <= SQ_W'(a_g.mx) * SQ_W'(a_g.mx);
      b_sqy <= SQ_W'(a_g.my) * SQ_W'(a_g.my);
      b_g   <= a_g;
      c_sum <= b_sqx + b_sqy;
      c_g   <= b_g;
    end
  end

  plc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (c_v),
    .rad      (c_sum),
    .in_geom  (c_g),
    .out_valid(s_v),
    .root     (s_root),
    .out_geom (s_g)
  );

  // stage D: length test, penetration, bounce, division operands
  assign dist_e = CMP_W'(s_root);
  assign len_e  = CMP_W'(link_length);
  assign over   = dist_e - len_e;
  assign under  = len_e - dist_e;

  always_comb begin
    side_next         = '0;
    side_next.zero    = s_root == '0;
    side_next.sx      = s_g.sx;
    side_next.sy      = s_g.sy;
    if (link_kind == LINK_CABLE) begin
      side_next.contact = dist_e >= len_e;
      if (side_next.contact) begin
        side_next.pen    = PEN_W'(over);
        side_next.bounce = (restitution > REST_ONE) ? REST_ONE : restitution;
      end
    end else begin
      side_next.contact = dist_e != len_e;
      if (dist_e > len_e) begin
        side_next.pen = PEN_W'(over);
      end else if (side_next.contact) begin
        side_next.pen  = PEN_W'(under);
        side_next.flip = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (en) begin
      d_v <= s_v;
    end
    if (en) begin
      d_side <= side_next;
      d_nx   <= (NUM_W'(s_g.mx) << NORM_FRAC) + NUM_W'(s_root >> 1);
      d_ny   <= (NUM_W'(s_g.my) << NORM_FRAC) + NUM_W'(s_root >> 1);
      d_den  <= s_root;
    end
  end

  plc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d_v),
    .num_x    (d_nx),
    .num_y    (d_ny),
    .den      (d_den),
    .in_side  (d_side),
    .out_valid(q_v),
    .quo_x    (q_x),
    .quo_y    (q_y),
    .out_side (q_side)
  );

  // output register: sign, zero distance and no-contact cleanup
  assign mag_x = NORM_W'(q_x);
  assign mag_y = NORM_W'(q_y);
  assign show  = q_side.contact && !q_side.zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= q_v;
    end
    if (en) begin
      res.contact_made <= q_side.contact;
      res.normal_x     <= !show ? '0 : ((q_side.sx ^ q_side.flip) ? -mag_x : mag_x);
      res.normal_y     <= !show ? '0 : ((q_side.sy ^ q_side.flip) ? -mag_y : mag_y);
      res.penetration  <= q_side.pen;
      res.bounce       <= q_side.bounce;
    end
  end

endmodule

// ===== hdl/plc_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module plc_sqrt import plc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SQ_W-1:0]   rad,
  input  geom_t             in_geom,
  output logic              out_valid,
  output logic [DIST_W-1:0] root,
  output geom_t             out_geom
);

  logic              v    [1:DIST_W];
  logic [SQ_W-1:0]   num  [1:DIST_W-1];
  logic [DIST_W:0]   rem  [1:DIST_W-1];
  logic [DIST_W-1:0] res  [1:DIST_W];
  geom_t             gm   [1:DIST_W];

  for (genvar i = 0; i < DIST_W; i++) begin : g_st
    logic              vi;
    logic [SQ_W-1:0]   ni;
    logic [DIST_W:0]   ri;
    logic [DIST_W-1:0] qi;
    geom_t             gi;
    logic [DIST_W+2:0] trial;
    logic [DIST_W+2:0] diff;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign ni = rad;
      assign ri = '0;
      assign qi = '0;
      assign gi = in_geom;
    end else begin : g_rest
      assign vi = v[i];
      assign ni = num[i];
      assign ri = rem[i];
      assign qi = res[i];
      assign gi = gm[i];
    end

    assign trial = {ri, ni[SQ_W-1 -: 2]};
    assign diff  = trial - {1'b0, qi, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= vi;
      end
      if (en) begin
        res[i+1] <= {qi[DIST_W-2:0], ~diff[DIST_W+2]};
        gm[i+1]  <= gi;
      end
    end

    if (i < DIST_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          num[i+1] <= ni << 2;
          rem[i+1] <= diff[DIST_W+2] ? trial[DIST_W:0] : diff[DIST_W:0];
        end
      end
    end
  end

  assign out_valid = v[DIST_W];
  assign root      = res[DIST_W];
  assign out_geom  = gm[DIST_W];

endmodule

// ===== hdl/plc_div.sv =====
// Pipelined restoring divider for both normal components, one quotient bit per stage.
module plc_div import plc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num_x,
  input  logic [NUM_W-1:0]  num_y,
  input  logic [DIST_W-1:0] den,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo_x,
  output logic [Q_W-1:0]    quo_y,
  output side_t             out_side
);

  logic              v  [1:Q_W];
  logic [NUM_W-1:0]  rx [1:Q_W-1];
  logic [NUM_W-1:0]  ry [1:Q_W-1];
  logic [DIST_W-1:0] dn [1:Q_W-1];
  logic [Q_W-1:0]    qx [1:Q_W];
  logic [Q_W-1:0]    qy [1:Q_W];
  side_t             sd [1:Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_st
    localparam int K = Q_W - 1 - i;
    logic              vi;
    logic [NUM_W-1:0]  rxi;
    logic [NUM_W-1:0]  ryi;
    logic [DIST_W-1:0] di;
    logic [Q_W-1:0]    qxi;
    logic [Q_W-1:0]    qyi;
    side_t             si;
    logic [NUM_W-1:0]  sh;
    logic              gx;
    logic              gy;

    if (i == 0) begin : g_first
      assign vi  = in_valid;
      assign rxi = num_x;
      assign ryi = num_y;
      assign di  = den;
      assign qxi = '0;
      assign qyi = '0;
      assign si  = in_side;
    end else begin : g_rest
      assign vi  = v[i];
      assign rxi = rx[i];
      assign ryi = ry[i];
      assign di  = dn[i];
      assign qxi = qx[i];
      assign qyi = qy[i];
      assign si  = sd[i];
    end

    assign sh = NUM_W'(di) << K;
    assign gx = rxi >= sh;
    assign gy = ryi >= sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= vi;
      end
      if (en) begin
        qx[i+1] <= qxi | (Q_W'(gx) << K);
        qy[i+1] <= qyi | (Q_W'(gy) << K);
        sd[i+1] <= si;
      end
    end

    if (i < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rx[i+1] <= gx ? rxi - sh : rxi;
          ry[i+1] <= gy ? ryi - sh : ryi;
          dn[i+1] <= di;
        end
      end
    end
  end

  assign out_valid = v[Q_W];
  assign quo_x     = qx[Q_W];
  assign quo_y     = qy[Q_W];
  assign out_side  = sd[Q_W];

endmodule

// ===== hdl/plc_check.sv =====
// Port-level assertions for the particle link contact block, bound to the top level.
module plc_check import plc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     contact_made,
  input logic signed [NORM_W-1:0] normal_x,
  input logic signed [NORM_W-1:0] normal_y,
  input logic [PEN_W-1:0]         penetration,
  input logic [REST_W-1:0]        bounce
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !contact_made |->
      normal_x == '0 && normal_y == '0 && penetration == '0 && bounce == '0)
    else $error("no-contact word carries nonzero payload");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
                  normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
                  bounce <= REST_ONE)
    else $error("normal or bounce out of range");

endmodule

bind particle_link_contact plc_check u_plc_check (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (pos.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .contact_made(res.contact_made),
  .normal_x    (res.normal_x),
  .normal_y    (res.normal_y),
  .penetration (res.penetration),
  .bounce      (res.bounce)
);

// ===== tb/testbench.sv =====
// Testbench for particle_link_contact: directed and random pairs against a local predictor.
`timescale 1ns / 1ps
module testbench;
  import plc_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic signed [31:0] ax, ay, bx, by;
  } pair_t;

  typedef struct {
    logic              contact;
    logic [15:0]       nx, ny;
    logic [31:0]       pen;
    logic [REST_W-1:0] bounce;
  } contact_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [IDX_W-1:0] cfg_index = REG_KIND;
  logic [CFG_W-1:0] cfg_data = '0;

  plc_pos_if pos();
  plc_res_if res();

  particle_link_contact uut(.clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
                            .cfg_data(cfg_data), .pos(pos), .res(res));

  always #5 clk = ~clk;

  logic              kind_m;
  logic [LEN_W-1:0]  length_m;
  logic [REST_W-1:0] rest_m;

  pair_t    pair_q[$];
  contact_t contact_q[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_hits = 0;
  longint cycles = 0;
  int src_wait = 0, snk_wait = 0;
  bit no_idle = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, n_got);
  endtask

  function automatic longint diff_sat(input logic signed [31:0] b, input logic signed [31:0] a);
    longint d;
    d = longint'(b) - longint'(a);
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    return d;
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] unit_part(input longint c, input logic [63:0] span,
                                            input bit flip);
    logic [63:0] m, q;
    if (span == 0) return 16'd0;
    m = (c < 0) ? 64'(-c) : 64'(c);
    q = (m * 64'd16384 + span / 2) / span;
    if ((c < 0) != flip) q = 64'h10000 - q;
    return q[15:0];
  endfunction

  function automatic contact_t predict_contact(input pair_t p);
    contact_t r;
    longint dx, dy;
    logic [63:0] mx, my, span;
    bit flip;
    dx = diff_sat(p.bx, p.ax);
    dy = diff_sat(p.by, p.ay);
    mx = (dx < 0) ? 64'(-dx) : 64'(dx);
    my = (dy < 0) ? 64'(-dy) : 64'(dy);
    span = root64(mx * mx + my * my);
    r = '{default: '0};
    flip = 0;
    if (kind_m == LINK_CABLE) begin
      r.contact = span >= length_m;
      if (r.contact) begin
        r.pen = 32'(span - length_m);
        r.bounce = (rest_m > REST_ONE) ? REST_ONE : rest_m;
      end
    end else begin
      r.contact = span != length_m;
      if (span > length_m) r.pen = 32'(span - length_m);
      else if (r.contact) begin
        r.pen = 32'(length_m - span);
        flip = 1;
      end
    end
    if (r.contact) begin
      r.nx = unit_part(dx, span, flip);
      r.ny = unit_part(dy, span, flip);
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      pos.valid <= 0;
    end else if (pos.valid && !pos.ready) begin
    end else begin
      if (pos.valid) begin
        contact_q.push_back(predict_contact('{pos.pos_a_x, pos.pos_a_y, pos.pos_b_x,
                                              pos.pos_b_y}));
        n_sent++;
      end
      if (src_wait > 0) begin
        src_wait <= src_wait - 1;
        pos.valid <= 0;
      end else if (pair_q.size() > 0) begin
        pair_t p;
        p = pair_q.pop_front();
        pos.pos_a_x <= p.ax;
        pos.pos_a_y <= p.ay;
        pos.pos_b_x <= p.bx;
        pos.pos_b_y <= p.by;
        pos.valid <= 1;
        src_wait <= no_idle ? 0 : $urandom_range(0, 7);
      end else begin
        pos.valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 0;
    end else begin
      if (res.valid && res.ready) begin
        contact_t w;
        n_got++;
        if (contact_q.size() == 0) begin
          errors++;
          $display("MISMATCH unexpected result word %0d", n_got);
        end else begin
          w = contact_q.pop_front();
          if (res.contact_made) n_hits++;
          if (res.contact_made !== w.contact) report("contact_made", res.contact_made, w.contact);
          if (res.normal_x !== w.nx) report("normal_x", res.normal_x, w.nx);
          if (res.normal_y !== w.ny) report("normal_y", res.normal_y, w.ny);
          if (res.penetration !== w.pen) report("penetration", res.penetration, w.pen);
          if (res.bounce !== w.bounce) report("bounce", res.bounce, w.bounce);
        end
      end
      if (snk_wait > 0) begin
        snk_wait <= snk_wait - 1;
        res.ready <= 0;
      end else begin
        res.ready <= 1;
        snk_wait <= no_idle ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : 0);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_KIND) kind_m = val[0];
    else if (idx == REG_LENGTH) length_m = val[LEN_W-1:0];
    else if (idx == REG_REST) rest_m = val[REST_W-1:0];
  endtask

  task automatic drain();
    while (pair_q.size() > 0 || pos.valid || contact_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rnd_coord(input logic signed [31:0] base);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'sh7fffffff - $urandom_range(0, 3);
      2: return 32'sh80000000 + $urandom_range(0, 3);
      default: return base + $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endcase
  endfunction

  // about half or the full link length along the x or y axis, zero distance, or anywhere
  function automatic pair_t rnd_pair();
    pair_t p;
    logic signed [31:0] cx, cy;
    int sel;
    cx = $urandom;
    cy = $urandom;
    sel = $urandom_range(0, 9);
    p.ax = cx;
    p.ay = cy;
    if (sel < 6) begin
      p.bx = cx + (($urandom_range(0, 1)) ? 1 : -1) * $signed({1'b0, length_m[30:1]})
             + $signed($urandom_range(0, 6)) - 3;
      p.by = cy + $signed($urandom_range(0, 6)) - 3;
      if (sel < 3) begin
        p.bx = cx + $signed($urandom_range(0, 4)) - 2;
        p.by = cy + (($urandom_range(0, 1)) ? 1 : -1) * $signed({1'b0, length_m})
               + $signed($urandom_range(0, 4)) - 2;
      end
    end else if (sel == 6) begin
      p.bx = cx;
      p.by = cy;
    end else begin
      p.bx = rnd_coord(cx);
      p.by = rnd_coord(cy);
    end
    return p;
  endfunction

  logic [LEN_W-1:0] lengths[6] = '{31'd0, 31'd65536, 31'h7fffffff, 31'd1, 31'd200000, 31'd3};
  logic [REST_W-1:0] rests[6] = '{17'd0, 17'd65536, 17'h1ffff, 17'd32768, 17'd65537, 17'd1};

  initial begin
    pos.valid = 0;
    pos.pos_a_x = 0; pos.pos_a_y = 0; pos.pos_b_x = 0; pos.pos_b_y = 0;
    res.ready = 0;
    kind_m = LINK_CABLE;
    length_m = LENGTH_RESET;
    rest_m = REST_RESET;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed at reset settings
    pair_q.push_back('{0, 0, 0, 0});
    pair_q.push_back('{0, 0, 32'sh10000, 0});
    pair_q.push_back('{0, 0, 32'shffff, 0});
    pair_q.push_back('{0, 0, 0, -32'sh20000});
    pair_q.push_back('{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff});
    pair_q.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000});
    pair_q.push_back('{32'sh7fffffff, 0, 32'sh80000000, 0});
    pair_q.push_back('{0, 32'sh80000000, 0, 32'sh7fffffff});
    pair_q.push_back('{32'h12345678, -32'sh5555, 32'h12345678 + 32'sh30000, 32'sh30000});
    pair_q.push_back('{-1, -1, 32'h0000c000, 32'h0000c000});
    drain();
    write_reg(REG_KIND, LINK_ROD);
    write_reg(REG_SPARE, 31'h5a5a);
    pair_q.push_back('{0, 0, 0, 0});
    pair_q.push_back('{0, 0, 32'sh10000, 0});
    pair_q.push_back('{0, 0, 32'sh8000, 32'sh8000});
    pair_q.push_back('{5, 7, 5 - 32'sh30000, 7 + 32'sh100});
    pair_q.push_back('{-32'sh11111, 32'sh22, -32'sh11111, -32'sh10000});
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_KIND, ph[0]);
      write_reg(REG_LENGTH, ph < 6 ? lengths[ph] : {$urandom} >> ($urandom_range(1, 16)));
      write_reg(REG_REST, ph < 6 ? rests[ph] : 31'($urandom_range(0, 17'h1ffff)));
      no_idle = (ph % 4 == 3);
      for (int i = 0; i < 95; i++) pair_q.push_back(rnd_pair());
      drain();
    end
    $display("Covered %0d pairs over 12 cable/rod settings, %0d contacts seen.", n_sent, n_hits);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
